[rtl/core/fmn_pkg.sv]
// Package for the frequency to MIDI note converter.
// Types and fixed constants; depends on nothing.
`default_nettype none

package fmn_pkg;

    localparam int FREQ_W   = 24;    // Q16.8 frequency word
    localparam int POS_W    = 5;     // leading-one index 0..23
    localparam int MANT_W   = 31;    // Q1.30 mantissa
    localparam int NOTE_W   = 7;
    localparam int BEND_W   = 7;

    localparam int REF_NOTE = 57;    // A3
    localparam int PERCENT  = 100;
    localparam int NOTE_MAX = 127;

    localparam logic [FREQ_W-1:0] REF_RESET = 24'd56320;  // 220.0 Hz

    typedef struct packed {
        logic f_zero;
        logic ref_zero;
    } t_flags;

    // Index of the highest set bit, 0 for a zero word.
    function automatic logic [POS_W-1:0] lead_one(input logic [FREQ_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < FREQ_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/frequency_to_midi_note_top.sv]
// Frequency to MIDI note converter, top level.
// Pipelined log2 of input and reference, note and bend rounding; uses fmn_pkg.
`default_nettype none

// Usage:
//   Input channel: i_valid / o_stall with i_freq_in (unsigned Q16.8 Hz). An item is
//   taken at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_midi_note, o_bend_percent (two's
//   complement percent of a semitone) and o_out_of_range.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into the A3 reference frequency
//   (Q16.8 Hz, 220.0 Hz after reset). Write it only while the pipeline is empty.
//   The input's fraction bits cancel, since both logs see the same scaling.
// Stages: LOG_FRAC_BITS + 5 register stages: normalize, one per log fraction bit,
//   log difference, fractional note, note and clamp, and output.
// Throughput: one item per cycle while o_stall is low. Each fraction bit of the log
//   is one stage with a 31x31 squaring multiplier per lane (input and reference).
// Reset: synchronous on i_rst_n low; all stages empty, reference back to 220 Hz.
// Stall: each stage holds while the one after it is full and held, so bubbles
//   are squeezed out; o_stall rises only when every stage holds an item and the
//   output is stalled. Nothing is dropped or repeated.

module frequency_to_midi_note_top #(
    parameter int LOG_FRAC_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [fmn_pkg::FREQ_W-1:0]    i_cfg_wr_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [fmn_pkg::FREQ_W-1:0]    i_freq_in,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [fmn_pkg::NOTE_W-1:0]         o_midi_note,
    output logic signed [fmn_pkg::BEND_W-1:0]  o_bend_percent,
    output logic                               o_out_of_range
);
    import fmn_pkg::*;

    localparam int LFB  = LOG_FRAC_BITS;
    localparam int NS   = LFB + 5;
    localparam int S_D  = LFB + 1;        // log difference
    localparam int S_X  = LFB + 2;        // biased fractional note
    localparam int S_N  = LFB + 3;        // note, clamp, |remainder|
    localparam int S_O  = LFB + 4;        // output register
    localparam int DW   = LFB + POS_W + 1;
    localparam int XW   = LFB + 11;
    localparam int NW   = XW - LFB;
    localparam int SW   = LFB + 7;
    localparam logic signed [XW-1:0] XH_BIAS =
        XW'((REF_NOTE * (2 ** LFB)) + (2 ** (LFB - 1)));
    localparam logic [SW-1:0] SC_HALF = SW'(2 ** (LFB - 1));

    // reference register
    logic [FREQ_W-1:0] r_ref_a_freq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_a_freq <= REF_RESET;
        end else if (i_cfg_wr_en) begin
            r_ref_a_freq <= i_cfg_wr_data;
        end
    end

    // stage valids and load enables
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[S_O];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // normalize and squaring stages, input lane (f) and reference lane (r)
    logic [MANT_W-1:0] r_mf [0:LFB];
    logic [MANT_W-1:0] r_mr [0:LFB];
    logic [POS_W-1:0]  r_pf [0:LFB];
    logic [POS_W-1:0]  r_pr [0:LFB];
    t_flags            r_flg [0:LFB];
    t_flags            r_flg_d;
    t_flags            r_flg_x;
    logic [LFB-1:0]    r_ff [1:LFB];
    logic [LFB-1:0]    r_fr [1:LFB];

    logic [POS_W-1:0]  pos_f, pos_r;
    logic [MANT_W-1:0] n_mf [1:LFB];
    logic [MANT_W-1:0] n_mr [1:LFB];
    logic              n_bf [1:LFB];
    logic              n_br [1:LFB];

    assign pos_f = lead_one(i_freq_in);
    assign pos_r = lead_one(r_ref_a_freq);

    always_comb begin
        logic [2*MANT_W-1:0] prod_f, prod_r;
        for (int k = 1; k <= LFB; k++) begin
            prod_f  = r_mf[k-1] * r_mf[k-1];
            prod_r  = r_mr[k-1] * r_mr[k-1];
            // square in Q2.60; renormalize into [1,2) and emit one log bit
            n_bf[k] = prod_f[2*MANT_W-1];
            n_br[k] = prod_r[2*MANT_W-1];
            n_mf[k] = n_bf[k] ? prod_f[2*MANT_W-1:MANT_W] : prod_f[2*MANT_W-2:MANT_W-1];
            n_mr[k] = n_br[k] ? prod_r[2*MANT_W-1:MANT_W] : prod_r[2*MANT_W-2:MANT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_mf[0]  <= MANT_W'(i_freq_in) << (POS_W'(MANT_W - 1) - pos_f);
            r_mr[0]  <= MANT_W'(r_ref_a_freq) << (POS_W'(MANT_W - 1) - pos_r);
            r_pf[0]  <= pos_f;
            r_pr[0]  <= pos_r;
            r_flg[0] <= '{f_zero: (i_freq_in == '0), ref_zero: (r_ref_a_freq == '0)};
        end
        for (int k = 1; k <= LFB; k++) begin
            if (en[k]) begin
                r_mf[k]  <= n_mf[k];
                r_mr[k]  <= n_mr[k];
                r_pf[k]  <= r_pf[k-1];
                r_pr[k]  <= r_pr[k-1];
                r_flg[k] <= r_flg[k-1];
                if (k == 1) begin
                    r_ff[k] <= LFB'(n_bf[k]);
                    r_fr[k] <= LFB'(n_br[k]);
                end else begin
                    r_ff[k] <= {r_ff[k-1][LFB-2:0], n_bf[k]};
                    r_fr[k] <= {r_fr[k-1][LFB-2:0], n_br[k]};
                end
            end
        end
    end

    // log difference
    logic signed [POS_W:0]  pos_diff;
    logic signed [DW-1:0]   n_d;
    logic signed [DW-1:0]   r_d;

    assign pos_diff = $signed({1'b0, r_pf[LFB]}) - $signed({1'b0, r_pr[LFB]});
    assign n_d      = $signed({pos_diff, {LFB{1'b0}}})
                    + $signed(DW'(r_ff[LFB])) - $signed(DW'(r_fr[LFB]));

    always_ff @(posedge i_clk) begin
        if (en[S_D]) begin
            r_d     <= n_d;
            r_flg_d <= r_flg[LFB];
        end
    end

    // x + 0.5 = 57 + 12*d + 0.5
    logic signed [XW-1:0] d_ext;
    logic signed [XW-1:0] r_xh;

    assign d_ext = XW'(r_d);

    always_ff @(posedge i_clk) begin
        if (en[S_X]) begin
            r_xh    <= (d_ext <<< 3) + (d_ext <<< 2) + XH_BIAS;
            r_flg_x <= r_flg_d;
        end
    end

    // note = floor(x + 0.5); remainder r = x - note lies in [-0.5, 0.5)
    logic signed [NW-1:0] note_s;
    logic [LFB-1:0]       rem;
    logic                 n_neg;
    logic [LFB-1:0]       n_mag;
    logic [NOTE_W-1:0]    n_note;
    logic                 n_oor;
    logic                 n_bend_en;

    logic                 r_neg;
    logic [LFB-1:0]       r_mag;
    logic [NOTE_W-1:0]    r_note;
    logic                 r_oor;
    logic                 r_bend_en;

    assign note_s = $signed(r_xh[XW-1:LFB]);
    assign rem    = {~r_xh[LFB-1], r_xh[LFB-2:0]};
    assign n_neg  = rem[LFB-1];
    assign n_mag  = n_neg ? (~rem + LFB'(1)) : rem;

    always_comb begin
        n_note    = note_s[NOTE_W-1:0];
        n_oor     = 1'b1;
        n_bend_en = 1'b0;
        priority if (r_flg_x.f_zero) begin
            n_note = '0;
        end else if (r_flg_x.ref_zero) begin
            n_note = NOTE_W'(NOTE_MAX);
        end else if (note_s[NW-1]) begin
            n_note = '0;
        end else if (note_s > $signed(NW'(NOTE_MAX))) begin
            n_note = NOTE_W'(NOTE_MAX);
        end else begin
            n_oor     = 1'b0;
            n_bend_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_N]) begin
            r_neg      <= n_neg;
            r_mag      <= n_mag;
            r_note     <= n_note;
            r_oor      <= n_oor;
            r_bend_en  <= n_bend_en;
        end
    end

    // bend = round(100 * |r|), sign restored
    logic [SW-1:0]     scaled;
    logic [BEND_W-1:0] bend_mag;
    logic [BEND_W-1:0] n_bend;

    logic [NOTE_W-1:0]        r_out_note;
    logic signed [BEND_W-1:0] r_out_bend;
    logic                     r_out_oor;

    assign scaled   = SW'(r_mag) * SW'(PERCENT) + SC_HALF;
    assign bend_mag = scaled[SW-1:LFB];
    assign n_bend   = !r_bend_en ? '0 : (r_neg ? (~bend_mag + BEND_W'(1)) : bend_mag);

    always_ff @(posedge i_clk) begin
        if (en[S_O]) begin
            r_out_note <= r_note;
            r_out_bend <= $signed(n_bend);
            r_out_oor  <= r_oor;
        end
    end

    assign o_midi_note    = r_out_note;
    assign o_bend_percent = r_out_bend;
    assign o_out_of_range = r_out_oor;

    // checks
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a pipeline stage is empty");

    a_clamp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |->
            ((o_bend_percent == '0) &&
             ((o_midi_note == '0) || (o_midi_note == NOTE_W'(NOTE_MAX)))))
        else $error("out-of-range result with nonzero bend or unclamped note");

    a_bend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_of_range) |->
            ((o_bend_percent <= $signed(BEND_W'(50))) &&
             (o_bend_percent >= $signed(-BEND_W'(50)))))
        else $error("bend outside half a semitone");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
